@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by record_list_table_engine_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rlte_pkg.sv @@
// ----------------------------------------------------------------------------
// rlte_pkg
// Request and response words, operation and status codes of the record table.
// ----------------------------------------------------------------------------
package rlte_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam logic [2:0] REQ_APPEND   = 3'd0;
    localparam logic [2:0] REQ_PREPEND  = 3'd1;
    localparam logic [2:0] REQ_SORTED   = 3'd2;
    localparam logic [2:0] REQ_RM_LAST  = 3'd3;
    localparam logic [2:0] REQ_RM_FIRST = 3'd4;
    localparam logic [2:0] REQ_RM_KEY   = 3'd5;
    localparam logic [2:0] REQ_RD_INDEX = 3'd6;
    localparam logic [2:0] REQ_RD_KEY   = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] rec_key;
        logic [31:0]        rec_payload;
        logic [7:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic [31:0]        out_payload;
        logic [4:0]         entry_count;
        logic               is_full;
        logic               is_empty;
    } t_rsp;

endpackage

@@ rtl/record_list_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// record_list_table_engine_unit
// Dense ordered table of keyed records with append, prepend, sorted insert,
// removals and lookups, one response word per request word.
// ----------------------------------------------------------------------------
// One request word is taken at a time; o_in_stall is high until its response
// has been loaded into the output register, which may still be waiting while
// the next request is accepted. Searches and shifts step one record per cycle
// through the record memory (one read and one write port), so the time from one
// accepted request to the next is shortest for remove last and early full or
// empty outcomes and longest for a sorted insert landing ahead of held records,
// plus any time the output register spends stalled.
// No clearing pass: only data from positions below the count is ever used.
`include "assert_macros.svh"

module record_list_table_engine_unit #(
    parameter int CAPACITY     = rlte_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = rlte_pkg::PAYLOAD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rlte_pkg::t_req i_in_word,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rlte_pkg::t_rsp o_out_word
);
    import rlte_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW    = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_UP, S_UP_LAST, S_DN, S_DN_LAST,
        S_WRITE, S_RD, S_RD_WAIT, S_DONE
    } t_state;

    // record memory
    logic signed [31:0] mem_key [CAPACITY];
    logic [PW-1:0]      mem_pay [CAPACITY];
    logic signed [31:0] r_rd_key;
    logic [PW-1:0]      r_rd_pay;

    t_state             r_state;
    logic [2:0]         r_op;
    logic signed [31:0] r_key;
    logic [PW-1:0]      r_pay;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_at;
    logic               r_rv;
    logic               r_wv;
    logic [IDX_W-1:0]   r_wadr;
    logic [1:0]         r_status;
    logic signed [31:0] r_rkey;
    logic [PW-1:0]      r_rpay;
    logic               r_out_valid;
    t_rsp               r_out;

    logic               in_acc;
    logic [IDX_W-1:0]   rd_adr;
    logic               w_en;
    logic [IDX_W-1:0]   w_adr;
    logic signed [31:0] w_key;
    logic [PW-1:0]      w_pay;
    logic               scan_hit;
    logic [CNT_W-1:0]   scan_at;
    logic [CNT_W-1:0]   sort_at;
    logic               cnt_zero;
    logic               cnt_full;
    logic               shift_wr;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign cnt_zero = (r_count == '0);
    assign cnt_full = (r_count >= CNT_W'(CAPACITY));

    // data read last cycle belongs to position r_ptr - 1
    assign scan_at  = r_ptr - CNT_W'(1);
    assign scan_hit = r_rv && ((r_op == REQ_SORTED) ? (r_rd_key >= r_key)
                                                    : (r_rd_key == r_key));
    assign sort_at  = scan_hit ? scan_at : r_count;

    always_comb begin
        rd_adr = '0;
        unique case (r_state)
            S_SCAN:                 rd_adr = (r_ptr < r_count) ? IDX_W'(r_ptr) : '0;
            S_UP, S_DN:             rd_adr = IDX_W'(r_ptr);
            S_RD:                   rd_adr = IDX_W'(r_at);
            default:                rd_adr = '0;
        endcase
    end

    assign w_en  = r_wv || (r_state == S_WRITE);
    assign w_adr = (r_state == S_WRITE) ? IDX_W'(r_at) : r_wadr;
    assign w_key = (r_state == S_WRITE) ? r_key : r_rd_key;
    assign w_pay = (r_state == S_WRITE) ? r_pay : r_rd_pay;

    assign shift_wr = (r_state == S_UP) || (r_state == S_UP_LAST) || (r_state == S_DN) ||
                      (r_state == S_DN_LAST) || (r_state == S_WRITE);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem_key[w_adr] <= w_key;
            mem_pay[w_adr] <= w_pay;
        end
        r_rd_key <= mem_key[rd_adr];
        r_rd_pay <= mem_pay[rd_adr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rv        <= 1'b0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_wv <= 1'b0;
                    if (in_acc) begin
                        r_op     <= i_in_word.req_type;
                        r_key    <= i_in_word.rec_key;
                        r_pay    <= i_in_word.rec_payload[PW-1:0];
                        r_rkey   <= '0;
                        r_rpay   <= '0;
                        r_rv     <= 1'b0;
                        unique case (i_in_word.req_type) inside
                            REQ_APPEND, REQ_PREPEND, REQ_SORTED: begin
                                r_status <= cnt_full ? ST_FULL : ST_OK;
                                if (cnt_full) begin
                                    r_state  <= S_DONE;
                                end else if (i_in_word.req_type == REQ_APPEND) begin
                                    r_at    <= r_count;
                                    r_state <= S_WRITE;
                                end else if (i_in_word.req_type == REQ_PREPEND) begin
                                    r_at <= '0;
                                    if (cnt_zero) begin
                                        r_state <= S_WRITE;
                                    end else begin
                                        r_ptr   <= r_count - CNT_W'(1);
                                        r_state <= S_UP;
                                    end
                                end else begin
                                    r_ptr   <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_RM_LAST: begin
                                r_status <= cnt_zero ? ST_EMPTY : ST_OK;
                                if (!cnt_zero) begin
                                    r_count <= r_count - CNT_W'(1);
                                end
                                r_state <= S_DONE;
                            end
                            REQ_RM_FIRST: begin
                                r_status <= cnt_zero ? ST_EMPTY : ST_OK;
                                if (cnt_zero) begin
                                    r_state  <= S_DONE;
                                end else if (r_count == CNT_W'(1)) begin
                                    r_count <= '0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_ptr   <= CNT_W'(1);
                                    r_state <= S_DN;
                                end
                            end
                            REQ_RM_KEY, REQ_RD_KEY: begin
                                r_status <= cnt_zero ? ST_EMPTY : ST_OK;
                                if (cnt_zero) begin
                                    r_state  <= S_DONE;
                                end else begin
                                    r_ptr   <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_RD_INDEX: begin
                                if (CMP_W'(i_in_word.position) >= CMP_W'(r_count)) begin
                                    r_status <= ST_ERROR;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_at     <= CNT_W'(i_in_word.position);
                                    r_state  <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!scan_hit && (r_ptr < r_count)) begin
                        r_ptr <= r_ptr + CNT_W'(1);
                        r_rv  <= 1'b1;
                    end else if (r_op == REQ_SORTED) begin
                        r_at <= sort_at;
                        r_wv <= 1'b0;
                        if (sort_at == r_count) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_ptr   <= r_count - CNT_W'(1);
                            r_state <= S_UP;
                        end
                    end else if (!scan_hit) begin
                        r_status <= ST_ERROR;
                        r_state  <= S_DONE;
                    end else if (r_op == REQ_RD_KEY) begin
                        r_rkey  <= r_rd_key;
                        r_rpay  <= r_rd_pay;
                        r_state <= S_DONE;
                    end else if (scan_at + CNT_W'(1) == r_count) begin
                        // match is the last record: nothing to close up
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_wv    <= 1'b0;
                        r_ptr   <= scan_at + CNT_W'(1);
                        r_state <= S_DN;
                    end
                end
                S_UP: begin
                    r_wv   <= 1'b1;
                    r_wadr <= IDX_W'(r_ptr + CNT_W'(1));
                    if (r_ptr == r_at) begin
                        r_state <= S_UP_LAST;
                    end else begin
                        r_ptr <= r_ptr - CNT_W'(1);
                    end
                end
                S_UP_LAST: begin
                    r_wv    <= 1'b0;
                    r_state <= S_WRITE;
                end
                S_DN: begin
                    r_wv   <= 1'b1;
                    r_wadr <= IDX_W'(r_ptr - CNT_W'(1));
                    if (r_ptr == r_count - CNT_W'(1)) begin
                        r_state <= S_DN_LAST;
                    end else begin
                        r_ptr <= r_ptr + CNT_W'(1);
                    end
                end
                S_DN_LAST: begin
                    r_wv    <= 1'b0;
                    r_count <= r_count - CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_WRITE: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_RD: begin
                    r_state <= S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    r_rkey  <= r_rd_key;
                    r_rpay  <= r_rd_pay;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.status      <= r_status;
                        r_out.out_key     <= r_rkey;
                        r_out.out_payload <= 32'(r_rpay);
                        r_out.entry_count <= 5'(r_count);
                        r_out.is_full     <= (r_count == CNT_W'(CAPACITY));
                        r_out.is_empty    <= (r_count == '0);
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "count overflow")
    `ASSERT_ALWAYS(a_write_state, i_clk, i_rst_n, !w_en || shift_wr, "stray memory write")
    `ASSERT_ALWAYS(a_idle_no_write, i_clk, i_rst_n, r_state != S_IDLE || !r_wv, "write in idle")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall, "not busy after accept")

endmodule
